/* hdl/i2cwr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_pkg
// Shared types and constants of the I2C write/read transaction sequencer.
// ----------------------------------------------------------------------------
package i2cwr_pkg;

	// write buffer
	localparam int WRITE_DEPTH = 16;
	localparam int IDX_W       = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// request codes as they arrive on the input word
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_EVENT = 2'd1,
		REQ_LOAD  = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	// bus action codes of a result word
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_REFUSED = 3'd2,
		ACT_DATA    = 3'd3,
		ACT_RESTART = 3'd4,
		ACT_RECEIVE = 3'd5,
		ACT_BYTE    = 3'd6,
		ACT_STOP    = 3'd7
	} act_t;

	// transaction phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_TX   = 3'b010,
		PH_RX   = 3'b100
	} phase_t;

	// classified command, front -> queue -> back
	typedef struct packed {
		req_kind_t   kind;
		logic [6:0]  addr;
		logic [4:0]  wcnt;     // already saturated to WRITE_DEPTH
		logic [7:0]  rcnt;
		logic        load_ok;  // load index within the buffer
		logic [3:0]  lidx;
		logic [7:0]  ldat;
		logic        nack;
		logic [7:0]  rxb;
		logic        lbusy;
	} cmd_t;

	// result word
	typedef struct packed {
		act_t        action;
		logic [7:0]  tx_byte;
		logic        ack_next;
		logic        rx_valid;
		logic [7:0]  rx_data;
		logic [7:0]  rx_index;
		logic        busy_res;
		logic        nack_abort;
	} res_t;

endpackage
`default_nettype wire

/* hdl/i2cwr_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_req_if
// Request channel: valid/ready handshake with the request word fields.
// ----------------------------------------------------------------------------
interface i2cwr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [6:0] slave_addr;
	logic [4:0] write_count;
	logic [7:0] read_count;
	logic [3:0] load_index;
	logic [7:0] load_data;
	logic       got_nack;
	logic [7:0] rx_byte;
	logic       bus_line_busy;

	modport source (
		output valid, req_type, slave_addr, write_count, read_count,
		       load_index, load_data, got_nack, rx_byte, bus_line_busy,
		input  ready
	);
	modport sink (
		input  valid, req_type, slave_addr, write_count, read_count,
		       load_index, load_data, got_nack, rx_byte, bus_line_busy,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/i2cwr_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_res_if
// Result channel: valid/ready handshake with the result word fields.
// ----------------------------------------------------------------------------
interface i2cwr_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] tx_byte;
	logic       ack_next;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] rx_index;
	logic       busy_res;
	logic       nack_abort;

	modport source (
		output valid, action, tx_byte, ack_next, rx_valid, rx_data, rx_index,
		       busy_res, nack_abort,
		input  ready
	);
	modport sink (
		input  valid, action, tx_byte, ack_next, rx_valid, rx_data, rx_index,
		       busy_res, nack_abort,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/i2c_master_write_read_sequencer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer_top
// Byte-level I2C master sequencer for combined write-then-read transactions.
// ----------------------------------------------------------------------------
// Every request word yields exactly one result word, in order. Request types:
// start (address, write count, read count), byte-complete event (ACK/NACK and
// received byte) and write buffer load. A start is refused while a
// transaction runs or the line monitor reports busy. Throughput is one word
// per clock while results are taken: the back end retires one command per
// cycle against its state registers unless a result word waits unread. A
// word waits in the command queue until retired into the result register.
// The request side keeps accepting while a result waits, until the
// two-entry command queue fills. Write buffer entries must be loaded before
// they are sent; an entry never loaded sends an unspecified byte.
// ----------------------------------------------------------------------------
module i2c_master_write_read_sequencer_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cwr_req_if.sink   req_ch,
	i2cwr_res_if.source res_ch
);
	import i2cwr_pkg::*;

	// front -> queue
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;

	// queue -> back
	logic q_pop;
	logic q_head_valid;
	cmd_t q_head_cmd;

	// decode and classify request words
	i2cwr_front u_front (
		.req_ch   (req_ch),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (q_push_cmd)
	);

	// decouples the request side from a stalled result side
	i2cwr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head_cmd)
	);

	// transaction state, write buffer and registered result word
	i2cwr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_cmd   (q_head_cmd),
		.pop        (q_pop),
		.res_ch     (res_ch)
	);
endmodule
`default_nettype wire

/* hdl/i2cwr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_front
// Takes request words, decodes the request type, saturates the write count
// and range-checks the load index, then pushes a command into the queue.
// ----------------------------------------------------------------------------
module i2cwr_front (
	i2cwr_req_if.sink         req_ch,
	input  wire logic         q_full,
	output logic              push,
	output i2cwr_pkg::cmd_t   push_cmd
);
	import i2cwr_pkg::*;

	assign req_ch.ready = !q_full;
	assign push         = req_ch.valid && !q_full;

	always_comb begin
		push_cmd.kind    = req_kind_t'(req_ch.req_type);
		push_cmd.addr    = req_ch.slave_addr;
		if (32'(req_ch.write_count) > WRITE_DEPTH) begin
			push_cmd.wcnt = 5'(WRITE_DEPTH);
		end else begin
			push_cmd.wcnt = req_ch.write_count;
		end
		push_cmd.rcnt    = req_ch.read_count;
		push_cmd.load_ok = (32'(req_ch.load_index) < WRITE_DEPTH);
		push_cmd.lidx    = req_ch.load_index;
		push_cmd.ldat    = req_ch.load_data;
		push_cmd.nack    = req_ch.got_nack;
		push_cmd.rxb     = req_ch.rx_byte;
		push_cmd.lbusy   = req_ch.bus_line_busy;
	end
endmodule
`default_nettype wire

/* hdl/i2cwr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_queue
// Short command FIFO between front and back; head is shown combinationally.
// ----------------------------------------------------------------------------
module i2cwr_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire i2cwr_pkg::cmd_t  push_cmd,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output i2cwr_pkg::cmd_t       head_cmd
);
	import i2cwr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (32'(count_q) == QUEUE_DEPTH);
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/i2cwr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2cwr_back
// Transaction engine: holds the write buffer and transaction state, runs one
// command per cycle unless its result is held, and registers the result word.
// ----------------------------------------------------------------------------
module i2cwr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire i2cwr_pkg::cmd_t  head_cmd,
	output logic                  pop,
	i2cwr_res_if.source           res_ch
);
	import i2cwr_pkg::*;

	// write buffer, no reset
	logic [7:0] store_q [WRITE_DEPTH];

	phase_t     phase_q,         phase_d;
	logic [6:0] target_addr_q,   target_addr_d;
	logic [4:0] write_total_q,   write_total_d;
	logic [4:0] written_q,       written_d;
	logic [7:0] read_total_q,    read_total_d;
	logic [7:0] read_so_far_q,   read_so_far_d;
	logic       write_first_q,   write_first_d;
	logic       restart_done_q,  restart_done_d;

	logic       out_valid_q;
	res_t       res_q, res_d;

	logic [7:0] store_rd;
	logic [8:0] rsf_p1, rsf_p2;

	assign pop = head_valid && (!out_valid_q || res_ch.ready);

	assign store_rd = (32'(written_q) < WRITE_DEPTH) ? store_q[IDX_W'(written_q)] : 8'h00;
	assign rsf_p1   = {1'b0, read_so_far_q} + 9'd1;
	assign rsf_p2   = {1'b0, read_so_far_q} + 9'd2;

	always_comb begin
		phase_d        = phase_q;
		target_addr_d  = target_addr_q;
		write_total_d  = write_total_q;
		written_d      = written_q;
		read_total_d   = read_total_q;
		read_so_far_d  = read_so_far_q;
		write_first_d  = write_first_q;
		restart_done_d = restart_done_q;
		res_d          = '0;
		res_d.action   = ACT_NONE;

		case (head_cmd.kind)
			REQ_START: begin
				if (phase_q != PH_IDLE || head_cmd.lbusy) begin
					res_d.action = ACT_REFUSED;
				end else begin
					target_addr_d  = head_cmd.addr;
					write_total_d  = head_cmd.wcnt;
					written_d      = '0;
					read_total_d   = head_cmd.rcnt;
					read_so_far_d  = '0;
					restart_done_d = 1'b0;
					write_first_d  = (head_cmd.wcnt != '0);
					phase_d        = PH_TX;
					res_d.action   = ACT_START;
					res_d.tx_byte  = {head_cmd.addr, (head_cmd.wcnt == '0)};
				end
			end
			REQ_EVENT: begin
				if (phase_q == PH_TX) begin
					if (!write_first_q || (restart_done_q && !head_cmd.nack)) begin
						phase_d        = PH_RX;
						res_d.action   = ACT_RECEIVE;
						res_d.ack_next = !(read_total_q > 8'd1);
					end else if (written_q >= write_total_q && read_total_q == '0) begin
						phase_d      = PH_IDLE;
						res_d.action = ACT_STOP;
					end else if (head_cmd.nack) begin
						// slave refused a write byte or the read address
						phase_d          = PH_IDLE;
						res_d.action     = ACT_STOP;
						res_d.nack_abort = 1'b1;
					end else if (written_q < write_total_q) begin
						res_d.action  = ACT_DATA;
						res_d.tx_byte = store_rd;
						written_d     = written_q + 5'd1;
					end else begin
						restart_done_d = 1'b1;
						res_d.action   = ACT_RESTART;
						res_d.tx_byte  = {target_addr_q, 1'b1};
					end
				end else if (phase_q == PH_RX) begin
					if (rsf_p1 < {1'b0, read_total_q}) begin
						res_d.action   = ACT_BYTE;
						res_d.ack_next = !(rsf_p2 < {1'b0, read_total_q});
						res_d.rx_valid = 1'b1;
						res_d.rx_data  = head_cmd.rxb;
						res_d.rx_index = read_so_far_q;
						read_so_far_d  = read_so_far_q + 8'd1;
					end else begin
						// last byte, if any, rides along with the stop
						if (read_so_far_q < read_total_q) begin
							res_d.rx_valid = 1'b1;
							res_d.rx_data  = head_cmd.rxb;
							res_d.rx_index = read_so_far_q;
							read_so_far_d  = read_so_far_q + 8'd1;
						end
						phase_d      = PH_IDLE;
						res_d.action = ACT_STOP;
					end
				end
			end
			default: begin
				// loads and unknown codes leave the transaction alone
			end
		endcase

		res_d.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk) begin
		if (pop && head_cmd.kind == REQ_LOAD && head_cmd.load_ok) begin
			store_q[IDX_W'(head_cmd.lidx)] <= head_cmd.ldat;
		end
		if (pop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			target_addr_q  <= '0;
			write_total_q  <= '0;
			written_q      <= '0;
			read_total_q   <= '0;
			read_so_far_q  <= '0;
			write_first_q  <= 1'b0;
			restart_done_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				phase_q        <= phase_d;
				target_addr_q  <= target_addr_d;
				write_total_q  <= write_total_d;
				written_q      <= written_d;
				read_total_q   <= read_total_d;
				read_so_far_q  <= read_so_far_d;
				write_first_q  <= write_first_d;
				restart_done_q <= restart_done_d;
				out_valid_q    <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.action     = res_q.action;
	assign res_ch.tx_byte    = res_q.tx_byte;
	assign res_ch.ack_next   = res_q.ack_next;
	assign res_ch.rx_valid   = res_q.rx_valid;
	assign res_ch.rx_data    = res_q.rx_data;
	assign res_ch.rx_index   = res_q.rx_index;
	assign res_ch.busy_res   = res_q.busy_res;
	assign res_ch.nack_abort = res_q.nack_abort;
endmodule
`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C combined write/read transaction sequencer.
// Directed words hit the corner cases, then randomized transactions with
// random gaps and stalls on both channels. A local model of the sequencer
// predicts one result word per request word; results are checked in order.
// ----------------------------------------------------------------------------
module tb;
	import i2cwr_pkg::*;

	// request word as the bench builds it
	typedef struct {
		req_kind_t  kind;
		logic [6:0] addr;
		logic [4:0] wcnt;
		logic [7:0] rcnt;
		logic [3:0] lidx;
		logic [7:0] ldat;
		logic       nack;
		logic [7:0] rxb;
		logic       lbusy;
	} req_word_t;

	localparam int RANDOM_WORDS = 1200;
	localparam int MAX_WAIT     = 17;
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int HOLD_AFTER   = 300;   // words sent before the hold-off
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	i2cwr_req_if req_ch ();
	i2cwr_res_if res_ch ();

	i2c_master_write_read_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.res_ch (res_ch)
	);

	// stimulus and scoreboard
	req_word_t pending_words[$];
	res_t      bus_actions_due[$];
	bit        loaded[WRITE_DEPTH];    // store entries the stimulus has written
	int        words_queued = 0;
	int        words_sent   = 0;
	int        faults       = 0;

	// handshake flags: set at the rising edge, consumed at the falling edge
	bit req_taken = 0;
	bit res_taken = 0;
	bit hold_off  = 0;

	// sender / receiver pacing
	int send_gap   = 0;
	int recv_stall = 0;
	bit send_burst = 0;
	bit recv_burst = 0;

	// ------------------------------------------------------------------
	// Sequencer model state
	// ------------------------------------------------------------------
	phase_t     seq_phase    = PH_IDLE;
	logic       seq_active   = 1'b0;
	logic [6:0] tgt_addr     = '0;
	logic [4:0] wr_total     = '0;
	logic [4:0] wr_done      = '0;
	logic [7:0] rd_total     = '0;
	logic [7:0] rd_done      = '0;
	logic       writes_first = 1'b0;
	logic       restarted    = 1'b0;
	logic [7:0] wr_store[WRITE_DEPTH];

	// Advance the model by one request word, return the bus action it causes.
	function automatic res_t bus_step(req_word_t w);
		res_t       r;
		logic [4:0] wsat;
		r = '0;
		r.action = ACT_NONE;
		case (w.kind)
			REQ_START: begin
				if (seq_active || w.lbusy) begin
					r.action = ACT_REFUSED;
				end else begin
					// write count saturates at the buffer depth
					wsat = (int'(w.wcnt) > WRITE_DEPTH) ? 5'(WRITE_DEPTH) : w.wcnt;
					tgt_addr     = w.addr;
					wr_total     = wsat;
					wr_done      = '0;
					rd_total     = w.rcnt;
					rd_done      = '0;
					restarted    = 1'b0;
					writes_first = (wsat != 0);
					seq_phase    = PH_TX;
					seq_active   = 1'b1;
					r.action     = ACT_START;
					r.tx_byte    = {w.addr, ~writes_first};
				end
			end
			REQ_LOAD: begin
				if (int'(w.lidx) < WRITE_DEPTH)
					wr_store[w.lidx] = w.ldat;
			end
			REQ_EVENT: begin
				if (seq_phase == PH_TX) begin
					if (!writes_first || (restarted && !w.nack)) begin
						// read-only address NACK is not checked
						seq_phase  = PH_RX;
						r.action   = ACT_RECEIVE;
						r.ack_next = (int'(rd_total) > 1) ? 1'b0 : 1'b1;
					end else if (wr_done >= wr_total && rd_total == 0) begin
						// last write byte done, NACK or not: plain stop
						seq_phase  = PH_IDLE;
						seq_active = 1'b0;
						r.action   = ACT_STOP;
					end else if (w.nack) begin
						seq_phase    = PH_IDLE;
						seq_active   = 1'b0;
						r.action     = ACT_STOP;
						r.nack_abort = 1'b1;
					end else if (wr_done < wr_total) begin
						r.tx_byte = wr_store[4'(wr_done)];
						wr_done   = wr_done + 1'b1;
						r.action  = ACT_DATA;
					end else begin
						restarted = 1'b1;
						r.action  = ACT_RESTART;
						r.tx_byte = {tgt_addr, 1'b1};
					end
				end else if (seq_phase == PH_RX) begin
					if (int'(rd_done) + 1 < int'(rd_total)) begin
						r.ack_next = (int'(rd_done) + 2 < int'(rd_total)) ? 1'b0 : 1'b1;
						r.rx_valid = 1'b1;
						r.rx_data  = w.rxb;
						r.rx_index = rd_done;
						rd_done    = rd_done + 1'b1;
						r.action   = ACT_BYTE;
					end else begin
						// final byte rides on the stop; none when count is zero
						if (rd_done < rd_total) begin
							r.rx_valid = 1'b1;
							r.rx_data  = w.rxb;
							r.rx_index = rd_done;
							rd_done    = rd_done + 1'b1;
						end
						seq_phase  = PH_IDLE;
						seq_active = 1'b0;
						r.action   = ACT_STOP;
					end
				end
				// events while idle fall through as no action
			end
			default: ;
		endcase
		r.busy_res = seq_active;
		return r;
	endfunction

	function automatic string fmt_res(res_t r);
		return $sformatf("act=%0d tx=%h ackn=%b rxv=%b rxd=%h rxi=%0d busy=%b abort=%b",
			r.action, r.tx_byte, r.ack_next, r.rx_valid, r.rx_data, r.rx_index,
			r.busy_res, r.nack_abort);
	endfunction

	function automatic int draw_wait(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// ------------------------------------------------------------------
	// Word builders
	// ------------------------------------------------------------------
	// all fields random, so don't-care fields toggle too
	function automatic req_word_t any_word();
		req_word_t w;
		w.kind  = req_kind_t'($urandom_range(0, 3));
		w.addr  = 7'($urandom);
		w.wcnt  = 5'($urandom);
		w.rcnt  = 8'($urandom);
		w.lidx  = 4'($urandom);
		w.ldat  = 8'($urandom);
		w.nack  = 1'($urandom);
		w.rxb   = 8'($urandom);
		w.lbusy = 1'($urandom);
		return w;
	endfunction

	task automatic push_word(req_word_t w);
		if (w.kind == REQ_LOAD)
			loaded[w.lidx] = 1'b1;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_load(int idx, logic [7:0] data);
		req_word_t w;
		w      = any_word();
		w.kind = REQ_LOAD;
		w.lidx = 4'(idx);
		w.ldat = data;
		push_word(w);
	endtask

	// a start may be accepted, so every entry it could send is loaded first
	task automatic push_start(logic [6:0] addr, int wcnt, int rcnt, bit lbusy);
		req_word_t w;
		int        weff;
		weff = (wcnt > WRITE_DEPTH) ? WRITE_DEPTH : wcnt;
		for (int i = 0; i < weff; i++)
			if (!loaded[i])
				push_load(i, 8'($urandom));
		w       = any_word();
		w.kind  = REQ_START;
		w.addr  = addr;
		w.wcnt  = 5'(wcnt);
		w.rcnt  = 8'(rcnt);
		w.lbusy = lbusy;
		push_word(w);
	endtask

	task automatic push_event(bit nack, logic [7:0] rxb);
		req_word_t w;
		w      = any_word();
		w.kind = REQ_EVENT;
		w.nack = nack;
		w.rxb  = rxb;
		push_word(w);
	endtask

	task automatic directed_words();
		req_word_t w;
		push_load(0, 8'h00);
		push_load(1, 8'hFF);
		push_load(2, 8'hA5);
		push_load(3, 8'h5A);
		push_event(1'b0, 8'hFF);             // event while idle: ignored
		w = any_word();
		w.kind = REQ_NONE;                   // unknown request type
		push_word(w);
		push_start(7'h7F, 2, 0, 1'b1);       // line busy: refused
		push_start(7'h7F, 2, 0, 1'b0);       // write-only, top address
		push_start(7'h00, 0, 1, 1'b0);       // refused while active
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'h00);
		push_event(1'b1, 8'h00);             // NACK on last byte, nothing to read
		push_start(7'h00, 0, 0, 1'b0);       // read-only, zero bytes
		push_event(1'b1, 8'h00);             // address NACK ignored
		push_event(1'b0, 8'hFF);             // stop, no byte
		push_start(7'h2A, 1, 2, 1'b0);
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'h00);             // repeated start
		push_event(1'b1, 8'h00);             // read address NACK: abort
		push_start(7'h55, 1, 3, 1'b0);       // full write then read
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'h00);
		push_event(1'b0, 8'hFF);
		push_event(1'b1, 8'h81);             // last byte with the stop
	endtask

	// mostly well-formed transactions, with noise and broken sequences
	task automatic random_transaction();
		int wsel, rsel, wcnt, rcnt, n, noise;
		req_word_t w;
		wsel = $urandom_range(0, 9);
		wcnt = (wsel < 7) ? $urandom_range(0, 4)
		     : (wsel < 9) ? $urandom_range(5, 16) : $urandom_range(17, 31);
		rsel = $urandom_range(0, 59);
		rcnt = (rsel == 0) ? $urandom_range(200, 255)
		     : (rsel < 12) ? $urandom_range(5, 20) : $urandom_range(0, 4);
		repeat ($urandom_range(0, 2))
			push_load($urandom_range(0, WRITE_DEPTH - 1), 8'($urandom));
		push_start(7'($urandom), wcnt, rcnt, $urandom_range(0, 9) == 0);
		// enough events to carry a clean run of this transaction to its stop
		n = ((wcnt > WRITE_DEPTH) ? WRITE_DEPTH : wcnt) + 2 + ((rcnt > 0) ? rcnt : 1);
		if ($urandom_range(0, 6) == 0)
			n = n + $urandom_range(0, 4) - 2;
		for (int i = 0; i < n; i++) begin
			noise = $urandom_range(0, 19);
			if (noise == 0) begin
				push_start(7'($urandom), $urandom_range(0, 31), $urandom_range(0, 4),
					1'($urandom));
			end else if (noise == 1) begin
				w = any_word();
				w.kind = REQ_NONE;
				push_word(w);
			end else if (noise == 2) begin
				push_load($urandom_range(0, WRITE_DEPTH - 1), 8'($urandom));
			end
			push_event($urandom_range(0, 11) == 0, 8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Request driver: changes at the falling edge, holds a word until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin : req_drive
		req_word_t w;
		if (arst_n) begin
			if (req_ch.valid && !req_taken) begin
				// word still waiting for ready
			end else begin
				req_taken = 0;
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					req_ch.req_type      <= w.kind;
					req_ch.slave_addr    <= w.addr;
					req_ch.write_count   <= w.wcnt;
					req_ch.read_count    <= w.rcnt;
					req_ch.load_index    <= w.lidx;
					req_ch.load_data     <= w.ldat;
					req_ch.got_nack      <= w.nack;
					req_ch.rx_byte       <= w.rxb;
					req_ch.bus_line_busy <= w.lbusy;
					req_ch.valid         <= 1'b1;
					// gap before the next word; bursts run with no gaps
					if ($urandom_range(0, 24) == 0)
						send_burst = !send_burst;
					send_gap = draw_wait(send_burst);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stall after each word, plus the hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin : res_drive
		if (arst_n) begin
			if (res_taken) begin
				res_taken = 0;
				if ($urandom_range(0, 24) == 0)
					recv_burst = !recv_burst;
				recv_stall = draw_wait(recv_burst);
			end
			if (hold_off) begin
				res_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Hold the result side off for a long stretch so the command queue
	// fills and the request side has to stall.
	initial begin
		while (words_sent < HOLD_AFTER)
			@(posedge clk);
		hold_off = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 0;
	end

	// ------------------------------------------------------------------
	// Rising edge: predict on accepted requests, check accepted results.
	// Prediction runs first so a same-edge result still finds its entry.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : score
		req_word_t w;
		res_t      seen;
		res_t      due;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				w.kind  = req_kind_t'(req_ch.req_type);
				w.addr  = req_ch.slave_addr;
				w.wcnt  = req_ch.write_count;
				w.rcnt  = req_ch.read_count;
				w.lidx  = req_ch.load_index;
				w.ldat  = req_ch.load_data;
				w.nack  = req_ch.got_nack;
				w.rxb   = req_ch.rx_byte;
				w.lbusy = req_ch.bus_line_busy;
				bus_actions_due.push_back(bus_step(w));
				words_sent++;
				req_taken = 1;
			end
			if (res_ch.valid && res_ch.ready) begin
				res_taken = 1;
				seen.action     = act_t'(res_ch.action);
				seen.tx_byte    = res_ch.tx_byte;
				seen.ack_next   = res_ch.ack_next;
				seen.rx_valid   = res_ch.rx_valid;
				seen.rx_data    = res_ch.rx_data;
				seen.rx_index   = res_ch.rx_index;
				seen.busy_res   = res_ch.busy_res;
				seen.nack_abort = res_ch.nack_abort;
				if (bus_actions_due.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected result word: %s", fmt_res(seen));
				end else begin
					due = bus_actions_due.pop_front();
					if (seen !== due) begin
						faults++;
						if (faults <= 10)
							$display("mismatch\n  expected %s\n  actual   %s",
								fmt_res(due), fmt_res(seen));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, build stimulus, wait for drain, verdict
	// ------------------------------------------------------------------
	initial begin
		int target;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_NONE;
		req_ch.slave_addr    = '0;
		req_ch.write_count   = '0;
		req_ch.read_count    = '0;
		req_ch.load_index    = '0;
		req_ch.load_data     = '0;
		req_ch.got_nack      = 1'b0;
		req_ch.rx_byte       = '0;
		req_ch.bus_line_busy = 1'b0;
		res_ch.ready         = 1'b0;
		for (int i = 0; i < WRITE_DEPTH; i++)
			loaded[i] = 1'b0;
		arst_n = 1'b0;

		directed_words();
		target = words_queued + RANDOM_WORDS;
		while (words_queued < target)
			random_transaction();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_sent < words_queued)
			@(posedge clk);
		while (bus_actions_due.size() > 0)
			@(posedge clk);
		// catch stray results after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (faults == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
hdl/i2cwr_pkg.sv
hdl/i2cwr_req_if.sv
hdl/i2cwr_res_if.sv
hdl/i2cwr_front.sv
hdl/i2cwr_queue.sv
hdl/i2cwr_back.sv
hdl/i2c_master_write_read_sequencer_top.sv
bench/tb.sv
